// File: src/pcv_pkg.sv
package pcv_pkg;

    localparam int KSIZE     = 3;
    localparam int N_CH      = 3;
    localparam int CH_W      = 8;
    localparam int PX_W      = 24;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int SHIFT_W   = 4;
    localparam int IDX_W     = 3;
    localparam int W_MIN     = 3;
    localparam int H_MIN     = 3;
    localparam int H_MAX     = 4095;
    localparam int CH_MAX    = 255;
    localparam int FW_RESET  = 640;
    localparam int FH_RESET  = 480;
    localparam int PEND_W    = 3;
    localparam int Q_DEPTH   = 8;
    localparam int Q_PTR_W   = 3;
    localparam int Q_CNT_W   = 4;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_KERNEL_LEFT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
    localparam logic [IDX_W-1:0] REG_KERNEL_RIGHT = 3'd4;
    localparam logic [IDX_W-1:0] REG_RESULT_SHIFT = 3'd5;

    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_CLAMP,
        ST_MUL_IN,
        ST_MUL_OUT,
        ST_MUL_FRAME,
        ST_GAP
    } t_seq_state;

    typedef struct packed {
        logic pixel;
        logic emit;
        logic mask_l;
        logic mask_r;
        logic mask_t;
        logic mask_b;
        logic frame_end;
    } t_item_ctl;

endpackage

// File: src/pcv_lane.sv
module pcv_lane #(
    parameter int WEIGHT_BITS = 8,
    localparam int SUM_W = WEIGHT_BITS + 11
) (
    input  logic                                i_clk,
    input  logic [pcv_pkg::PX_W-1:0]            i_pix [pcv_pkg::KSIZE],
    input  logic [3*WEIGHT_BITS-1:0]            i_weights,
    input  logic                                i_col_en,
    input  logic [pcv_pkg::KSIZE-1:0]           i_row_en,
    output logic signed [SUM_W-1:0]             o_part [pcv_pkg::N_CH]
);
    import pcv_pkg::*;

    localparam int PROD_W = WEIGHT_BITS + 9;

    logic signed [PROD_W-1:0] prod   [KSIZE][N_CH];
    logic signed [PROD_W-1:0] r_prod [KSIZE][N_CH];

    // one product per row and channel of this kernel column
    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int ch = 0; ch < N_CH; ch++) begin
                if (i_col_en && i_row_en[r]) begin
                    prod[r][ch] = PROD_W'($signed(i_weights[r*WEIGHT_BITS +: WEIGHT_BITS]))
                                * PROD_W'($signed({1'b0, i_pix[r][ch*CH_W +: CH_W]}));
                end else begin
                    prod[r][ch] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        for (int ch = 0; ch < N_CH; ch++) begin
            o_part[ch] <= SUM_W'(r_prod[0][ch]) + SUM_W'(r_prod[1][ch])
                        + SUM_W'(r_prod[2][ch]);
        end
    end

endmodule

// File: src/pcv_merge.sv
module pcv_merge #(
    parameter int WEIGHT_BITS = 8,
    localparam int SUM_W = WEIGHT_BITS + 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [SUM_W-1:0]           i_part [pcv_pkg::KSIZE][pcv_pkg::N_CH],
    input  logic                              i_valid,
    input  logic                              i_frame_end,
    input  logic [pcv_pkg::SHIFT_W-1:0]       i_shift,
    input  logic [pcv_pkg::PEND_W-1:0]        i_pending,
    output logic                              o_room,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pcv_pkg::PX_W-1:0]          o_data,
    output logic                              o_last
);
    import pcv_pkg::*;

    localparam int TOT_W = SUM_W + 2;

    logic signed [TOT_W-1:0] tot     [N_CH];
    logic signed [TOT_W-1:0] shifted [N_CH];
    logic [PX_W-1:0]         res;

    logic [PX_W-1:0]    r_q_data [Q_DEPTH];
    logic               r_q_last [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               pop;

    // add the column partials, floor shift, clip to pixel range
    always_comb begin
        for (int ch = 0; ch < N_CH; ch++) begin
            tot[ch] = TOT_W'(i_part[0][ch]) + TOT_W'(i_part[1][ch]) + TOT_W'(i_part[2][ch]);
            shifted[ch] = tot[ch] >>> i_shift;
            if (shifted[ch][TOT_W-1]) begin
                res[ch*CH_W +: CH_W] = '0;
            end else if (shifted[ch] > TOT_W'(CH_MAX)) begin
                res[ch*CH_W +: CH_W] = CH_W'(CH_MAX);
            end else begin
                res[ch*CH_W +: CH_W] = shifted[ch][CH_W-1:0];
            end
        end
    end

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_q_data[r_rd_ptr];
    assign o_last  = r_q_last[r_rd_ptr];
    // room for every result still in the pipeline plus one more
    assign o_room  = (r_cnt + Q_CNT_W'(i_pending)) < Q_CNT_W'(Q_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_q_data[r_wr_ptr] <= res;
            r_q_last[r_wr_ptr] <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_valid) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_valid) - Q_CNT_W'(pop);
        end
    end

endmodule

// File: src/pcv_ctrl.sv
module pcv_ctrl #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [WEFF_W-1:0]         i_w,
    input  logic [pcv_pkg::FH_W-1:0]  i_h,
    input  logic                      i_size_wr,
    input  logic                      i_op,
    input  logic                      i_accept,
    output logic                      o_run,
    output pcv_pkg::t_item_ctl        o_step,
    output logic [COL_W-1:0]          o_col
);
    import pcv_pkg::*;

    localparam int LIN_W = $clog2(MAX_WIDTH * H_MAX);
    localparam int MUL_W = FH_W + WEFF_W;

    t_seq_state r_state, n_state;

    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [FH_W-1:0]  r_in_row, r_out_row;
    logic [LIN_W-1:0] r_gap;
    logic [LIN_W-1:0] r_prod_in, r_prod_out, r_frame;

    logic             at_start, gap_le_w, take_flush, is_pixel, emit;
    logic             in_col_last, in_row_last, out_col_last, out_row_last;
    logic [FH_W-1:0]  mul_a;
    logic [MUL_W-1:0] mul_p;
    logic [LIN_W:0]   lin_in, lin_out;
    logic [LIN_W-1:0] gap_calc;

    // decision for the item at the input
    always_comb begin
        at_start     = (r_in_col == '0) && (r_in_row == '0);
        gap_le_w     = r_gap <= LIN_W'(i_w);
        take_flush   = at_start && (r_gap != '0) && ((i_op == OP_FLUSH) || gap_le_w);
        is_pixel     = (i_op != OP_FLUSH) && !take_flush;
        emit         = take_flush || (is_pixel && !gap_le_w);
        in_col_last  = (WEFF_W'(r_in_col) + WEFF_W'(1)) == i_w;
        in_row_last  = (r_in_row + FH_W'(1)) == i_h;
        out_col_last = (WEFF_W'(r_out_col) + WEFF_W'(1)) == i_w;
        out_row_last = (r_out_row + FH_W'(1)) == i_h;

        o_step.pixel     = is_pixel;
        o_step.emit      = emit;
        o_step.mask_l    = (r_out_col != '0);
        o_step.mask_r    = !out_col_last;
        o_step.mask_t    = (r_out_row != '0);
        o_step.mask_b    = !out_row_last;
        o_step.frame_end = out_row_last && out_col_last;
    end

    assign o_col = r_in_col;
    assign o_run = (r_state == ST_RUN);

    // shared multiplier for rebuilding the pending count
    always_comb begin
        case (r_state)
            ST_MUL_IN:  mul_a = r_in_row;
            ST_MUL_OUT: mul_a = r_out_row;
            default:    mul_a = i_h;
        endcase
        mul_p    = MUL_W'(mul_a) * MUL_W'(i_w);
        lin_in   = (LIN_W+1)'(r_prod_in) + (LIN_W+1)'(r_in_col);
        lin_out  = (LIN_W+1)'(r_prod_out) + (LIN_W+1)'(r_out_col);
        if (lin_in >= lin_out) begin
            gap_calc = LIN_W'(lin_in - lin_out);
        end else begin
            gap_calc = LIN_W'(lin_in + (LIN_W+1)'(r_frame) - lin_out);
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_size_wr) begin
            n_state = ST_CLAMP;
        end else begin
            unique case (r_state)
                ST_RUN:       n_state = ST_RUN;
                ST_CLAMP:     n_state = ST_MUL_IN;
                ST_MUL_IN:    n_state = ST_MUL_OUT;
                ST_MUL_OUT:   n_state = ST_MUL_FRAME;
                ST_MUL_FRAME: n_state = ST_GAP;
                ST_GAP:       n_state = ST_RUN;
                default:      n_state = ST_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_gap     <= '0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (i_accept) begin
                        if (is_pixel) begin
                            r_in_col <= in_col_last ? '0 : r_in_col + COL_W'(1);
                            if (in_col_last) begin
                                r_in_row <= in_row_last ? '0 : r_in_row + FH_W'(1);
                            end
                        end
                        if (emit) begin
                            r_out_col <= out_col_last ? '0 : r_out_col + COL_W'(1);
                            if (out_col_last) begin
                                r_out_row <= out_row_last ? '0 : r_out_row + FH_W'(1);
                            end
                        end
                        if (is_pixel && !emit) begin
                            r_gap <= r_gap + LIN_W'(1);
                        end else if (take_flush) begin
                            r_gap <= r_gap - LIN_W'(1);
                        end
                    end
                end
                ST_CLAMP: begin
                    if (WEFF_W'(r_in_col) >= i_w) begin
                        r_in_col <= '0;
                    end
                    if (r_in_row >= i_h) begin
                        r_in_row <= '0;
                    end
                    if (WEFF_W'(r_out_col) >= i_w) begin
                        r_out_col <= '0;
                    end
                    if (r_out_row >= i_h) begin
                        r_out_row <= '0;
                    end
                end
                ST_MUL_IN:    r_prod_in  <= LIN_W'(mul_p);
                ST_MUL_OUT:   r_prod_out <= LIN_W'(mul_p);
                ST_MUL_FRAME: r_frame    <= LIN_W'(mul_p);
                ST_GAP:       r_gap      <= gap_calc;
                default: ;
            endcase
        end
    end

endmodule

// File: src/pixel_convolution_3x3_unit.sv
// pipeline: input stage, window, lane product and sum registers, output queue;
// a pixel's result is released width+1 items later, flush items drain the last row
// throughput: one item per cycle while the output queue has room, set by the window
// and line store access; a frame size write stalls the input in the clamp,
// multiply and gap states while the shared multiplier rebuilds the pending count
// reset: synchronous active low, clears counters, window, pipeline and output queue
module pixel_convolution_3x3_unit #(
    parameter int MAX_WIDTH   = 1024,
    parameter int WEIGHT_BITS = 8,
    localparam int KW    = 3 * WEIGHT_BITS,
    localparam int CFG_W = (KW > pcv_pkg::FH_W) ? KW : pcv_pkg::FH_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,   // red_in, green_in, blue_in
    input  logic                        s_axis_tuser,   // op
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // red_out, green_out, blue_out
    output logic                        m_axis_tlast,
    input  logic                        i_cfg_we,
    input  logic [pcv_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data
);
    import pcv_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (FW_W > WEFF_W) ? FW_W : WEFF_W;
    localparam int SUM_W  = WEIGHT_BITS + 11;

    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [KW-1:0]      r_kernel_left, r_kernel_mid, r_kernel_right;
    logic [SHIFT_W-1:0] r_result_shift;

    logic [WEFF_W-1:0]  w_eff;
    logic [FH_W-1:0]    h_eff;
    logic               size_wr;
    logic               ctl_run, q_room, accept;
    t_item_ctl          step;
    logic [COL_W-1:0]   ctl_col;

    logic               r_s1_valid;
    t_item_ctl          r_s1_ctl;
    logic [PX_W-1:0]    r_s1_px;
    logic [COL_W-1:0]   r_s1_col;
    t_item_ctl          r_s2_ctl;
    logic               r_e2, r_e3, r_e4;
    logic               r_fe3, r_fe4;
    logic [PEND_W-1:0]  pending;

    logic [PX_W-1:0]    r_mem_older [MAX_WIDTH];
    logic [PX_W-1:0]    r_mem_newer [MAX_WIDTH];
    logic [PX_W-1:0]    r_older_q, r_newer_q;
    logic [PX_W-1:0]    r_win [KSIZE*KSIZE];

    logic [PX_W-1:0]    lane_pix    [KSIZE][KSIZE];
    logic [KW-1:0]      lane_weight [KSIZE];
    logic [KSIZE-1:0]   lane_col_en;
    logic [KSIZE-1:0]   lane_row_en;
    logic signed [SUM_W-1:0] lane_part [KSIZE][N_CH];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(FW_RESET);
            r_frame_height <= FH_W'(FH_RESET);
            r_kernel_left  <= '0;
            r_kernel_mid   <= KW'(1) << WEIGHT_BITS;
            r_kernel_right <= '0;
            r_result_shift <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                REG_KERNEL_LEFT:  r_kernel_left  <= i_cfg_data[KW-1:0];
                REG_KERNEL_MID:   r_kernel_mid   <= i_cfg_data[KW-1:0];
                REG_KERNEL_RIGHT: r_kernel_right <= i_cfg_data[KW-1:0];
                REG_RESULT_SHIFT: r_result_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign size_wr = i_cfg_we
                  && ((i_cfg_idx == REG_FRAME_WIDTH) || (i_cfg_idx == REG_FRAME_HEIGHT));

    always_comb begin
        if (r_frame_width < FW_W'(W_MIN)) begin
            w_eff = WEFF_W'(W_MIN);
        end else if (CMP_W'(r_frame_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(r_frame_width);
        end
        h_eff = (r_frame_height < FH_W'(H_MIN)) ? FH_W'(H_MIN) : r_frame_height;
    end

    assign s_axis_tready = ctl_run && q_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pcv_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_w       (w_eff),
        .i_h       (h_eff),
        .i_size_wr (size_wr),
        .i_op      (s_axis_tuser),
        .i_accept  (accept),
        .o_run     (ctl_run),
        .o_step    (step),
        .o_col     (ctl_col)
    );

    // line stores: read at the input column, written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_ctl.pixel) begin
            r_mem_older[r_s1_col] <= r_newer_q;
            r_mem_newer[r_s1_col] <= r_s1_px;
        end
        r_older_q <= r_mem_older[ctl_col];
        r_newer_q <= r_mem_newer[ctl_col];
    end

    always_ff @(posedge i_clk) begin
        r_s1_ctl <= step;
        r_s1_px  <= s_axis_tdata;
        r_s1_col <= ctl_col;
        r_s2_ctl <= r_s1_ctl;
        r_fe3    <= r_s2_ctl.frame_end;
        r_fe4    <= r_fe3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_e2       <= 1'b0;
            r_e3       <= 1'b0;
            r_e4       <= 1'b0;
            r_win      <= '{default: '0};
        end else begin
            r_s1_valid <= accept && (step.pixel || step.emit);
            r_e2       <= r_s1_valid && r_s1_ctl.emit;
            r_e3       <= r_e2;
            r_e4       <= r_e3;
            if (r_s1_valid) begin
                for (int i = 0; i < KSIZE*(KSIZE-1); i++) begin
                    r_win[i] <= r_win[i+KSIZE];
                end
                // zero column for a flush item
                r_win[KSIZE*(KSIZE-1)]   <= r_s1_ctl.pixel ? r_older_q : '0;
                r_win[KSIZE*(KSIZE-1)+1] <= r_s1_ctl.pixel ? r_newer_q : '0;
                r_win[KSIZE*(KSIZE-1)+2] <= r_s1_ctl.pixel ? r_s1_px : '0;
            end
        end
    end

    assign pending = PEND_W'(r_s1_valid && r_s1_ctl.emit) + PEND_W'(r_e2)
                   + PEND_W'(r_e3) + PEND_W'(r_e4);

    always_comb begin
        for (int c = 0; c < KSIZE; c++) begin
            for (int r = 0; r < KSIZE; r++) begin
                lane_pix[c][r] = r_win[c*KSIZE + r];
            end
        end
        lane_weight[0] = r_kernel_left;
        lane_weight[1] = r_kernel_mid;
        lane_weight[2] = r_kernel_right;
        lane_col_en    = {r_s2_ctl.mask_r, 1'b1, r_s2_ctl.mask_l};
        lane_row_en    = {r_s2_ctl.mask_b, 1'b1, r_s2_ctl.mask_t};
    end

    for (genvar c = 0; c < KSIZE; c++) begin : g_lane
        pcv_lane #(
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_pix     (lane_pix[c]),
            .i_weights (lane_weight[c]),
            .i_col_en  (lane_col_en[c]),
            .i_row_en  (lane_row_en),
            .o_part    (lane_part[c])
        );
    end

    pcv_merge #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_part      (lane_part),
        .i_valid     (r_e4),
        .i_frame_end (r_fe4),
        .i_shift     (r_result_shift),
        .i_pending   (pending),
        .o_room      (q_room),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

// File: src/pcv_checker.sv
module pcv_checker #(
    parameter int CFG_W = 24
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [23:0]                 s_axis_tdata,
    input logic                        s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [23:0]                 m_axis_tdata,
    input logic                        m_axis_tlast,
    input logic                        i_cfg_we,
    input logic [pcv_pkg::IDX_W-1:0]   i_cfg_idx,
    input logic [CFG_W-1:0]            i_cfg_data
);
    import pcv_pkg::*;

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // reset empties the output queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // a frame size write stalls the input while the pending count is rebuilt
    a_size_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == REG_FRAME_WIDTH || i_cfg_idx == REG_FRAME_HEIGHT)
        |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken during size update");

endmodule

bind pixel_convolution_3x3_unit pcv_checker #(.CFG_W(CFG_W)) u_pcv_checker (.*);

// File: verif/pixel_convolution_3x3_checker.sv
module pixel_convolution_3x3_checker
    import pcv_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CFG_W     = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // red_in, green_in, blue_in
    input  logic             s_axis_tuser,   // op
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [23:0]      m_axis_tdata,   // red_out, green_out, blue_out
    input  logic             m_axis_tlast,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // channel 0 is red, in the lowest byte
    typedef logic [N_CH-1:0][CH_W-1:0] rgb_t;
    // weight 0 is the row above, 2 the row below
    typedef logic [KSIZE-1:0][7:0] column_weights_t;

    typedef struct packed {
        rgb_t rgb;
        logic frame_end;
    } filtered_t;

    logic [FW_W-1:0]    width_reg;
    logic [FH_W-1:0]    height_reg;
    logic [SHIFT_W-1:0] shift_reg;
    column_weights_t    taps [KSIZE];

    rgb_t line_prev2 [MAX_WIDTH];
    rgb_t line_prev1 [MAX_WIDTH];
    rgb_t win [KSIZE][KSIZE];
    int unsigned in_x, in_y, out_x, out_y;

    filtered_t owed_pixels [$];
    int mismatches = 0;
    string chan_names [N_CH] = '{"red_out", "green_out", "blue_out"};

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic void reset_filter();
        width_reg = FW_RESET;
        height_reg = FH_RESET;
        shift_reg = '0;
        taps[0] = '0;
        taps[1] = 24'h000100;
        taps[2] = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_prev2[i] = '0;
            line_prev1[i] = '0;
        end
        for (int c = 0; c < KSIZE; c++) begin
            for (int r = 0; r < KSIZE; r++) begin
                win[c][r] = '0;
            end
        end
        in_x = 0;
        in_y = 0;
        out_x = 0;
        out_y = 0;
    endfunction

    function automatic void slide_window(input rgb_t top, input rgb_t mid, input rgb_t bot);
        for (int c = 0; c < KSIZE - 1; c++) begin
            for (int r = 0; r < KSIZE; r++) begin
                win[c][r] = win[c+1][r];
            end
        end
        win[KSIZE-1][0] = top;
        win[KSIZE-1][1] = mid;
        win[KSIZE-1][2] = bot;
    endfunction

    function automatic filtered_t filter_at(input int unsigned w, input int unsigned h);
        filtered_t res;
        int acc [N_CH];
        int wt;
        int q;
        for (int ch = 0; ch < N_CH; ch++) begin
            acc[ch] = 0;
        end
        for (int c = 0; c < KSIZE; c++) begin
            for (int r = 0; r < KSIZE; r++) begin
                // neighbours outside the frame count as zero
                if ((c == 0 && out_x == 0) || (c == KSIZE - 1 && out_x + 1 >= w)) continue;
                if ((r == 0 && out_y == 0) || (r == KSIZE - 1 && out_y + 1 >= h)) continue;
                wt = $signed(taps[c][r]);
                for (int ch = 0; ch < N_CH; ch++) begin
                    acc[ch] += wt * int'(win[c][r][ch]);
                end
            end
        end
        for (int ch = 0; ch < N_CH; ch++) begin
            q = acc[ch] >>> shift_reg;
            if (q < 0) q = 0;
            if (q > CH_MAX) q = CH_MAX;
            res.rgb[ch] = q[CH_W-1:0];
        end
        res.frame_end = (out_y + 1 == h) && (out_x + 1 == w);
        out_x++;
        if (out_x >= w) begin
            out_x = 0;
            out_y++;
            if (out_y >= h) out_y = 0;
        end
        return res;
    endfunction

    function automatic bit convolve_item(input logic op, input rgb_t px, output filtered_t res);
        int unsigned w, h, span, in_lin, out_lin, lag;
        bit at_start, as_flush;
        rgb_t above2, above1;
        res = '0;
        w = width_reg;
        if (w < W_MIN) w = W_MIN;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < H_MIN) h = H_MIN;
        if (h > H_MAX) h = H_MAX;
        if (in_x >= w) in_x = 0;
        if (in_y >= h) in_y = 0;
        if (out_x >= w) out_x = 0;
        if (out_y >= h) out_y = 0;

        span = w * h;
        in_lin = in_y * w + in_x;
        out_lin = out_y * w + out_x;
        if (out_lin > in_lin) in_lin += span;
        lag = in_lin - out_lin;
        at_start = (in_x == 0) && (in_y == 0);

        // once a drain has begun every item drains
        as_flush = (op == OP_FLUSH) || (at_start && lag >= 1 && lag <= w);
        if (as_flush) begin
            if (!at_start || lag == 0) return 1'b0;
            slide_window('0, '0, '0);
            res = filter_at(w, h);
            return 1'b1;
        end

        above2 = line_prev2[in_x];
        above1 = line_prev1[in_x];
        line_prev2[in_x] = above1;
        line_prev1[in_x] = px;
        slide_window(above2, above1, px);
        in_x++;
        if (in_x >= w) begin
            in_x = 0;
            in_y++;
            if (in_y >= h) in_y = 0;
        end
        if (lag >= w + 1) begin
            res = filter_at(w, h);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        filtered_t want;
        filtered_t fresh;
        rgb_t seen;
        if (!i_rst_n) begin
            reset_filter();
            owed_pixels.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_pixels.size() == 0) begin
                    $error("unexpected output transfer: tdata %h, tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end else begin
                    want = owed_pixels.pop_front();
                    seen = m_axis_tdata;
                    for (int ch = 0; ch < N_CH; ch++) begin
                        if (seen[ch] !== want.rgb[ch]) begin
                            $error("%s mismatch: expected %0d, actual %0d",
                                   chan_names[ch], want.rgb[ch], seen[ch]);
                            mismatches++;
                        end
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        $error("frame_end mismatch: expected %0d, actual %0d",
                               want.frame_end, m_axis_tlast);
                        mismatches++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  width_reg = i_cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = i_cfg_data[FH_W-1:0];
                    REG_KERNEL_LEFT:  taps[0] = i_cfg_data[23:0];
                    REG_KERNEL_MID:   taps[1] = i_cfg_data[23:0];
                    REG_KERNEL_RIGHT: taps[2] = i_cfg_data[23:0];
                    REG_RESULT_SHIFT: shift_reg = i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (convolve_item(s_axis_tuser, rgb_t'(s_axis_tdata), fresh)) begin
                    owed_pixels.push_back(fresh);
                end
            end
        end
        o_pending <= owed_pixels.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: verif/pixel_convolution_3x3_unit_tb.sv
module pixel_convolution_3x3_unit_tb;
    import pcv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 1024;
    localparam int CFG_W         = 24;
    localparam int ITEM_BUDGET   = 700;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 3_000_000;

    localparam logic             OP_PIXEL   = 1'b0;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata  = '0;   // red_in, green_in, blue_in
    logic             s_axis_tuser  = 1'b0; // op
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;         // red_out, green_out, blue_out
    logic             m_axis_tlast;
    logic             i_cfg_we      = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0] i_cfg_data    = '0;

    int mismatch_total;
    int results_owed;
    int cycle_count = 0;

    // frame size in use and the position of the next input pixel
    int cols = FW_RESET;
    int rows = FH_RESET;
    int col_at = 0;
    int row_at = 0;
    bit tx_quiet = 1'b0;

    pixel_convolution_3x3_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    pixel_convolution_3x3_checker #(
        .MAX_WIDTH (MAX_W),
        .CFG_W     (CFG_W)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (mismatch_total),
        .o_pending     (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int idle_cycles(input bit quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 16);
    endfunction

    function automatic logic [23:0] random_rgb();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 24'h000000;
        if (pick == 1) return 24'hFFFFFF;
        return $urandom() & 24'hFFFFFF;
    endfunction

    function automatic logic [23:0] pick_kernel();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h808080;
            3: return 24'h7F7F7F;
            4: return 24'h000100;
            default: return $urandom() & 24'hFFFFFF;
        endcase
    endfunction

    // receiver: bursts of ready broken by stalls, with some long calm stretches
    initial begin
        int n_on;
        int n_off;
        bit quiet;
        forever begin
            quiet = ($urandom_range(0, 3) == 0);
            n_on = quiet ? $urandom_range(50, 200) : $urandom_range(1, 12);
            n_off = idle_cycles(quiet);
            repeat (n_on) begin
                @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
            repeat (n_off) begin
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_WIDTH: begin
                cols = val[FW_W-1:0];
                if (cols < W_MIN) cols = W_MIN;
                if (cols > MAX_W) cols = MAX_W;
            end
            REG_FRAME_HEIGHT: begin
                rows = val[FH_W-1:0];
                if (rows < H_MIN) rows = H_MIN;
                if (rows > H_MAX) rows = H_MAX;
            end
            default: ;
        endcase
    endtask

    task automatic program_phase(input logic [FW_W-1:0] wv, input logic [FH_W-1:0] hv,
                                 input bit every);
        if (every || $urandom_range(0, 2) != 0) write_reg(REG_FRAME_WIDTH, wv);
        if (every || $urandom_range(0, 2) != 0) write_reg(REG_FRAME_HEIGHT, hv);
        if (every || $urandom_range(0, 1) == 0) write_reg(REG_KERNEL_LEFT, pick_kernel());
        if (every || $urandom_range(0, 1) == 0) write_reg(REG_KERNEL_MID, pick_kernel());
        if (every || $urandom_range(0, 1) == 0) write_reg(REG_KERNEL_RIGHT, pick_kernel());
        if (every || $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_RESULT_SHIFT, 0);
                1: write_reg(REG_RESULT_SHIFT, 15);
                default: write_reg(REG_RESULT_SHIFT, $urandom_range(0, 15));
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // called at a clock edge; returns at the edge of the transfer
    task automatic push_item(input logic op, input logic [23:0] px);
        int idle;
        idle = idle_cycles(tx_quiet);
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= px;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_pixel(input logic [23:0] px);
        push_item(OP_PIXEL, px);
        col_at++;
        if (col_at >= cols) begin
            col_at = 0;
            row_at++;
            if (row_at >= rows) row_at = 0;
        end
    endtask

    task automatic run_frame();
        tx_quiet = ($urandom_range(0, 3) == 0);
        repeat (cols * rows) begin
            // a flush inside a frame is dropped
            if ((col_at != 0 || row_at != 0) && $urandom_range(0, 19) == 0) begin
                push_item(OP_FLUSH, random_rgb());
            end
            send_pixel(random_rgb());
        end
    endtask

    // pixels sent while the last row drains are taken as flushes
    task automatic drain_frame();
        push_item(OP_FLUSH, random_rgb());
        repeat (cols) begin
            push_item(($urandom_range(0, 2) == 0) ? OP_PIXEL : OP_FLUSH, random_rgb());
        end
    endtask

    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [23:0] corner_px [9];
        int budget;
        int phase;
        int n_frames;
        bit big;
        corner_px = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                      24'h55AA55, 24'hAA55AA, 24'hFFFFFF, 24'h000000};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frames with a kernel that saturates both ways
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_KERNEL_LEFT, 24'hFFFFFF);
        write_reg(REG_KERNEL_MID, 24'hFF08FF);
        write_reg(REG_KERNEL_RIGHT, 24'h7F0180);
        write_reg(REG_RESULT_SHIFT, 0);
        write_reg(REG_UNUSED, '1);
        i_cfg_we <= 1'b0;

        push_item(OP_FLUSH, 24'hFFFFFF);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) push_item(OP_FLUSH, 24'h000000);
            send_pixel(corner_px[i]);
        end
        // next frame follows with no flush in between
        repeat (9) send_pixel(random_rgb());
        push_item(OP_FLUSH, random_rgb());
        push_item(OP_PIXEL, 24'hFFFFFF);
        push_item(OP_FLUSH, random_rgb());
        push_item(OP_FLUSH, random_rgb());
        push_item(OP_FLUSH, random_rgb());
        finish_phase();

        budget = ITEM_BUDGET;
        phase = 0;
        while (budget > 0) begin
            phase++;
            big = (phase == 1) || (phase == 3) || (phase == 5);
            case (phase)
                1: program_phase(11'd1024, 12'd3, 1'b1);
                3: program_phase(11'd0, 12'd4095, 1'b1);
                5: program_phase(11'd2047, 12'd0, 1'b1);
                default: program_phase(($urandom_range(0, 9) == 0) ?
                                           $urandom_range(0, 2) : $urandom_range(3, 10),
                                       ($urandom_range(0, 9) == 0) ?
                                           $urandom_range(0, 2) : $urandom_range(3, 6),
                                       1'b0);
            endcase
            n_frames = big ? 1 : $urandom_range(1, 3);
            repeat (n_frames) begin
                run_frame();
                if (!big) budget -= cols * rows;
            end
            drain_frame();
            budget -= cols + 1;
            // nothing left to drain, these are dropped
            repeat ($urandom_range(0, 2)) push_item(OP_FLUSH, random_rgb());
            finish_phase();
        end

        if (mismatch_total == 0 && results_owed == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/pcv_pkg.sv
src/pcv_lane.sv
src/pcv_merge.sv
src/pcv_ctrl.sv
src/pixel_convolution_3x3_unit.sv
src/pcv_checker.sv
verif/pixel_convolution_3x3_checker.sv
verif/pixel_convolution_3x3_unit_tb.sv
